### hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the attenuator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check an expression on every clock edge out of reset
`define DVA_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
// check that a condition implies a consequence on the same edge
`define DVA_ASSERT_IMPL(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("assertion failed");
`else
`define DVA_ASSERT(lbl, expr)
`define DVA_ASSERT_IMPL(lbl, cond, cons)
`endif
`endif

### hw/rtl/dva_pkg.sv
// Package: widths, codes, reset values and the pipeline tag of the attenuator.
package dva_pkg;
	localparam int RANGE_BITS     = 19;
	localparam int LEVEL_BITS     = 8;
	localparam int ACTION_BITS    = 3;
	localparam int VOL_BITS       = 8;
	localparam int SCALED_BITS    = 9;
	localparam int CFG_INDEX_BITS = 3;

	localparam int DEF_COORD_BITS      = 20;
	localparam int DEF_RATIO_FRAC_BITS = 16;
	localparam int DEF_FULL_VOLUME     = 128;

	// sound kinds
	localparam logic [ACTION_BITS-1:0] ACT_EXPLOSION    = 3'd0;
	localparam logic [ACTION_BITS-1:0] ACT_COLLISION    = 3'd1;
	localparam logic [ACTION_BITS-1:0] ACT_ENGINE_START = 3'd2;
	localparam logic [ACTION_BITS-1:0] ACT_ENGINE_UPD   = 3'd3;
	localparam logic [ACTION_BITS-1:0] ACT_MAIN_ENGINE  = 3'd4;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_MASTER     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_EXPL_RANGE = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COLL_RANGE = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ENG_RANGE  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAIN_LEVEL = 3'd4;

	// reset values
	localparam logic [LEVEL_BITS-1:0] RST_MASTER     = 8'd64;
	localparam logic [RANGE_BITS-1:0] RST_EXPL_RANGE = 19'd4096;
	localparam logic [RANGE_BITS-1:0] RST_COLL_RANGE = 19'd2048;
	localparam logic [RANGE_BITS-1:0] RST_ENG_RANGE  = 19'd2048;
	localparam logic [LEVEL_BITS-1:0] RST_MAIN_LEVEL = 8'd64;

	localparam logic [SCALED_BITS-1:0] SCALED_MAX = 9'd511;

	// side information that travels with each word down the pipeline
	typedef struct packed {
		logic [ACTION_BITS-1:0] action;
		logic [RANGE_BITS-1:0]  range;
		logic                   far;
		logic                   whole;  // source on the listener: ratio is exactly one
	} dva_tag_t;
endpackage

### hw/rtl/dva_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module dva_isqrt import dva_pkg::*; #(
	parameter int RB = RANGE_BITS,
	parameter int TW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [2*RB-1:0] in_rad,
	input  logic [TW-1:0]   in_tag,
	output logic            out_valid,
	output logic [RB-1:0]   out_root,
	output logic [TW-1:0]   out_tag
);
	logic            vld_s  [RB];
	logic [RB+1:0]   rem_s  [RB];
	logic [RB-1:0]   root_s [RB];
	logic [2*RB-1:0] rad_s  [RB];
	logic [TW-1:0]   tag_s  [RB];

	logic [RB+1:0]   nrem  [RB];
	logic [RB-1:0]   nroot [RB];
	logic [2*RB-1:0] nrad  [RB];
	logic [TW-1:0]   ntag  [RB];
	logic            nvld  [RB];
	logic [RB+1:0]   prem  [RB];
	logic [RB-1:0]   proot [RB];
	logic [2*RB-1:0] prad  [RB];
	logic [RB+3:0]   cur   [RB];
	logic [RB+3:0]   trial [RB];
	logic [RB+3:0]   diff  [RB];

	// one restoring step per stage: bring down two radicand bits, try root*4+1
	always_comb begin
		for (int k = 0; k < RB; k++) begin
			if (k == 0) begin
				prem[k]  = '0;
				proot[k] = '0;
				prad[k]  = in_rad;
				ntag[k]  = in_tag;
				nvld[k]  = in_valid;
			end else begin
				prem[k]  = rem_s[k-1];
				proot[k] = root_s[k-1];
				prad[k]  = rad_s[k-1];
				ntag[k]  = tag_s[k-1];
				nvld[k]  = vld_s[k-1];
			end
			cur[k]   = {prem[k], prad[k][2*RB-1 -: 2]};
			trial[k] = {2'b00, proot[k], 2'b01};
			diff[k]  = cur[k] - trial[k];
			if (cur[k] >= trial[k]) begin
				nrem[k]  = diff[k][RB+1:0];
				nroot[k] = {proot[k][RB-2:0], 1'b1};
			end else begin
				nrem[k]  = cur[k][RB+1:0];
				nroot[k] = {proot[k][RB-2:0], 1'b0};
			end
			nrad[k] = {prad[k][2*RB-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RB; k++) vld_s[k] <= 1'b0;
		end else begin
			for (int k = 0; k < RB; k++) vld_s[k] <= nvld[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < RB; k++) begin
			rem_s[k]  <= nrem[k];
			root_s[k] <= nroot[k];
			rad_s[k]  <= nrad[k];
			tag_s[k]  <= ntag[k];
		end
	end

	assign out_valid = vld_s[RB-1];
	assign out_root  = root_s[RB-1];
	assign out_tag   = tag_s[RB-1];
endmodule

### hw/rtl/dva_div.sv
// Pipelined restoring divider for a fraction num/den with num < den, one bit per stage.
module dva_div import dva_pkg::*; #(
	parameter int NB = RANGE_BITS,
	parameter int QB = DEF_RATIO_FRAC_BITS,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NB-1:0] in_num,
	input  logic [NB-1:0] in_den,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [QB-1:0] out_quot,
	output logic [TW-1:0] out_tag
);
	logic          vld_s [QB];
	logic [NB-1:0] rem_s [QB];
	logic [NB-1:0] den_s [QB];
	logic [QB-1:0] q_s   [QB];
	logic [TW-1:0] tag_s [QB];

	logic          nvld [QB];
	logic [NB-1:0] nrem [QB];
	logic [NB-1:0] nden [QB];
	logic [QB-1:0] nq   [QB];
	logic [TW-1:0] ntag [QB];
	logic [NB-1:0] prem [QB];
	logic [QB-1:0] pq   [QB];
	logic [NB:0]   t    [QB];
	logic          ge   [QB];

	// shift remainder, subtract divisor where it fits, shift the bit into the quotient
	always_comb begin
		for (int k = 0; k < QB; k++) begin
			if (k == 0) begin
				prem[k] = in_num;
				pq[k]   = '0;
				nden[k] = in_den;
				ntag[k] = in_tag;
				nvld[k] = in_valid;
			end else begin
				prem[k] = rem_s[k-1];
				pq[k]   = q_s[k-1];
				nden[k] = den_s[k-1];
				ntag[k] = tag_s[k-1];
				nvld[k] = vld_s[k-1];
			end
			t[k]  = {prem[k], 1'b0};
			ge[k] = t[k] >= {1'b0, nden[k]};
			nrem[k] = ge[k] ? NB'(t[k] - {1'b0, nden[k]}) : t[k][NB-1:0];
			nq[k]   = {pq[k][QB-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QB; k++) vld_s[k] <= 1'b0;
		end else begin
			for (int k = 0; k < QB; k++) vld_s[k] <= nvld[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QB; k++) begin
			rem_s[k] <= nrem[k];
			den_s[k] <= nden[k];
			q_s[k]   <= nq[k];
			tag_s[k] <= ntag[k];
		end
	end

	assign out_valid = vld_s[QB-1];
	assign out_quot  = q_s[QB-1];
	assign out_tag   = tag_s[QB-1];
endmodule

### hw/rtl/distance_volume_attenuator.sv
// Top level: distance attenuation and gain scaling of sound events.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------------
//  command   | start / busy               | action, sound_x/y, listener_x/y
//  result    | done (one-cycle strobe)    | volume, scaled_volume, audible
//  config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One word enters per cycle; busy stays low. A word passes stages 1 to 3, the
// bit-per-stage square root, stage 4, the bit-per-stage divider, stages 5 and 6
// and the output stage. Reset clears the valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
`include "assert_macros.svh"
module distance_volume_attenuator import dva_pkg::*; #(
	parameter int COORD_BITS      = DEF_COORD_BITS,
	parameter int RATIO_FRAC_BITS = DEF_RATIO_FRAC_BITS,
	parameter int FULL_VOLUME     = DEF_FULL_VOLUME
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [ACTION_BITS-1:0]    action,
	input  logic [COORD_BITS-1:0]     sound_x,
	input  logic [COORD_BITS-1:0]     sound_y,
	input  logic [COORD_BITS-1:0]     listener_x,
	input  logic [COORD_BITS-1:0]     listener_y,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [RANGE_BITS-1:0]     cfg_data,
	output logic                      done,
	output logic [VOL_BITS-1:0]       volume,
	output logic [SCALED_BITS-1:0]    scaled_volume,
	output logic                      audible
);
	localparam int DW = COORD_BITS + 1;
	localparam int CW = (DW > RANGE_BITS) ? DW : RANGE_BITS;
	localparam int SQ = 2 * RANGE_BITS;
	localparam int TW = $bits(dva_tag_t);
	localparam int F  = RATIO_FRAC_BITS;
	localparam int PW = 2 * F + 8;
	localparam int GW = 2 * LEVEL_BITS;

	// configuration registers
	logic [LEVEL_BITS-1:0] master_q, main_level_q;
	logic [RANGE_BITS-1:0] expl_range_q, coll_range_q, eng_range_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q     <= RST_MASTER;
			expl_range_q <= RST_EXPL_RANGE;
			coll_range_q <= RST_COLL_RANGE;
			eng_range_q  <= RST_ENG_RANGE;
			main_level_q <= RST_MAIN_LEVEL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MASTER:     master_q     <= cfg_data[LEVEL_BITS-1:0];
				REG_EXPL_RANGE: expl_range_q <= cfg_data;
				REG_COLL_RANGE: coll_range_q <= cfg_data;
				REG_ENG_RANGE:  eng_range_q  <= cfg_data;
				REG_MAIN_LEVEL: main_level_q <= cfg_data[LEVEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: absolute coordinate differences, range of the kind
	logic [DW-1:0] ddx, ddy, adx, ady;
	logic [RANGE_BITS-1:0] rng_sel;
	logic          valid_s1;
	logic [DW-1:0] dx_s1, dy_s1;
	dva_tag_t      tag_s1;

	always_comb begin
		ddx = {sound_x[COORD_BITS-1], sound_x} - {listener_x[COORD_BITS-1], listener_x};
		ddy = {sound_y[COORD_BITS-1], sound_y} - {listener_y[COORD_BITS-1], listener_y};
		adx = ddx[DW-1] ? DW'(-ddx) : ddx;
		ady = ddy[DW-1] ? DW'(-ddy) : ddy;
		case (action) inside
			ACT_EXPLOSION:                  rng_sel = expl_range_q;
			ACT_COLLISION:                  rng_sel = coll_range_q;
			ACT_ENGINE_START, ACT_ENGINE_UPD: rng_sel = eng_range_q;
			default:                        rng_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		dx_s1  <= adx;
		dy_s1  <= ady;
		tag_s1 <= '{action: action, range: rng_sel, far: 1'b0, whole: 1'b0};
	end

	// stage 2: per-axis range check and squares
	logic [CW-1:0] dxw, dyw, rgw;
	logic [RANGE_BITS-1:0] dxn, dyn;
	logic          valid_s2;
	logic [SQ-1:0] dx2_s2, dy2_s2, rsq_s2;
	dva_tag_t      tag_s2;

	always_comb begin
		dxw = CW'(dx_s1);
		dyw = CW'(dy_s1);
		rgw = CW'(tag_s1.range);
		dxn = dxw[RANGE_BITS-1:0];
		dyn = dyw[RANGE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else         valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		dx2_s2 <= SQ'(dxn) * SQ'(dxn);
		dy2_s2 <= SQ'(dyn) * SQ'(dyn);
		rsq_s2 <= SQ'(tag_s1.range) * SQ'(tag_s1.range);
		tag_s2 <= '{action: tag_s1.action, range: tag_s1.range,
			far: (dxw >= rgw) || (dyw >= rgw), whole: 1'b0};
	end

	// stage 3: squared distance and radial range check
	logic [SQ:0]   d2sum;
	logic          valid_s3;
	logic [SQ-1:0] d2_s3;
	dva_tag_t      tag_s3;

	assign d2sum = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else         valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		d2_s3  <= d2sum[SQ-1:0];
		tag_s3 <= '{action: tag_s2.action, range: tag_s2.range,
			far: tag_s2.far || (d2sum >= {1'b0, rsq_s2}), whole: 1'b0};
	end

	// square root
	logic                  sq_valid;
	logic [RANGE_BITS-1:0] sq_root;
	logic [TW-1:0]         sq_tag;

	dva_isqrt #(.RB(RANGE_BITS), .TW(TW)) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.in_rad    (d2_s3),
		.in_tag    (tag_s3),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_tag   (sq_tag)
	);

	// stage 4: distance left to the edge of the range
	dva_tag_t              sq_tag_c;
	logic                  valid_s4;
	logic [RANGE_BITS-1:0] num_s4;
	dva_tag_t              tag_s4;

	assign sq_tag_c = dva_tag_t'(sq_tag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else         valid_s4 <= sq_valid;
	end

	// zero distance gives a ratio of exactly one, which the divider cannot hold
	always_ff @(posedge clk) begin
		num_s4 <= sq_tag_c.range - sq_root;
		tag_s4 <= '{action: sq_tag_c.action, range: sq_tag_c.range,
			far: sq_tag_c.far, whole: sq_root == '0};
	end

	// ratio (range - d) / range in fixed point
	logic          dv_valid;
	logic [F-1:0]  dv_quot;
	logic [TW-1:0] dv_tag;

	dva_div #(.NB(RANGE_BITS), .QB(F), .TW(TW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.in_num    (num_s4),
		.in_den    (tag_s4.range),
		.in_tag    (tag_s4),
		.out_valid (dv_valid),
		.out_quot  (dv_quot),
		.out_tag   (dv_tag)
	);

	// stage 5: ratio squared
	logic           valid_s5;
	logic [2*F-1:0] rr_s5;
	dva_tag_t       tag_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s5 <= 1'b0;
		else         valid_s5 <= dv_valid;
	end

	always_ff @(posedge clk) begin
		rr_s5  <= (2 * F)'(dv_quot) * (2 * F)'(dv_quot);
		tag_s5 <= dva_tag_t'(dv_tag);
	end

	// stage 6: full-scale volume, blanked out of range, full at zero distance
	logic [PW-1:0]       full;
	logic                valid_s6;
	logic [VOL_BITS-1:0] vol_s6;
	dva_tag_t            tag_s6;

	assign full = PW'(FULL_VOLUME) * PW'(rr_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s6 <= 1'b0;
		else         valid_s6 <= valid_s5;
	end

	always_ff @(posedge clk) begin
		vol_s6 <= tag_s5.far ? '0 :
			(tag_s5.whole ? VOL_BITS'(FULL_VOLUME) : full[2*F +: VOL_BITS]);
		tag_s6 <= tag_s5;
	end

	// output stage: kind factor, master gain, saturation
	logic [LEVEL_BITS-1:0]  lvl;
	logic [GW-1:0]          prod;
	logic [GW-1:0]          sc;
	logic [VOL_BITS-1:0]    vol_o;
	logic                   aud_o;
	logic                   done_q;
	logic [VOL_BITS-1:0]    volume_q;
	logic [SCALED_BITS-1:0] scaled_q;
	logic                   audible_q;

	always_comb begin
		lvl  = (tag_s6.action == ACT_MAIN_ENGINE) ? main_level_q : vol_s6;
		prod = GW'(lvl) * GW'(master_q);
		case (tag_s6.action) inside
			ACT_EXPLOSION: begin
				sc    = prod >> 6;
				vol_o = vol_s6;
				aud_o = vol_s6 != '0;
			end
			ACT_COLLISION, ACT_ENGINE_START: begin
				sc    = prod >> 7;
				vol_o = vol_s6;
				aud_o = vol_s6 != '0;
			end
			ACT_ENGINE_UPD: begin
				sc    = prod >> 9;
				vol_o = vol_s6;
				aud_o = vol_s6 != '0;
			end
			ACT_MAIN_ENGINE: begin
				sc    = prod >> 7;
				vol_o = main_level_q;
				aud_o = 1'b1;
			end
			default: begin
				sc    = '0;
				vol_o = '0;
				aud_o = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= valid_s6;
	end

	always_ff @(posedge clk) begin
		volume_q  <= vol_o;
		scaled_q  <= (sc > GW'(SCALED_MAX)) ? SCALED_MAX : sc[SCALED_BITS-1:0];
		audible_q <= aud_o;
	end

	assign done          = done_q;
	assign volume        = volume_q;
	assign scaled_volume = scaled_q;
	assign audible       = audible_q;

	// checks
	`DVA_ASSERT_IMPL(a_silent_zero, done && !audible, volume == '0 && scaled_volume == '0)
	`DVA_ASSERT_IMPL(a_zero_vol_zero_scaled, done && volume == '0, scaled_volume == '0)
	`DVA_ASSERT(a_never_busy, !busy && cfg_ready)
endmodule

### bench/tb_top.sv
// Testbench for the distance volume attenuator: scoreboard class, drivers and top.
`timescale 1ns / 100ps

module tb_top;
	import dva_pkg::*;

	localparam int COORD_W  = DEF_COORD_BITS;
	localparam int LATENCY  = 7 + RANGE_BITS + DEF_RATIO_FRAC_BITS;
	localparam int PHASES   = 5;
	localparam int RAND_PER = 260;

	typedef struct {
		logic [VOL_BITS-1:0]    vol;
		logic [SCALED_BITS-1:0] scaled;
		logic                   aud;
	} sound_word_t;

	// predicts each result word from the commands and the register copies
	class attenuation_scoreboard;
		logic [LEVEL_BITS-1:0] master, main_level;
		logic [RANGE_BITS-1:0] expl_range, coll_range, eng_range;
		sound_word_t           pending_words[$];
		int                    errors;

		function new();
			master     = RST_MASTER;
			main_level = RST_MAIN_LEVEL;
			expl_range = RST_EXPL_RANGE;
			coll_range = RST_COLL_RANGE;
			eng_range  = RST_ENG_RANGE;
			errors     = 0;
		endfunction

		function void note_reg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [RANGE_BITS-1:0] data);
			case (idx)
				REG_MASTER:     master     = data[LEVEL_BITS-1:0];
				REG_EXPL_RANGE: expl_range = data;
				REG_COLL_RANGE: coll_range = data;
				REG_ENG_RANGE:  eng_range  = data;
				REG_MAIN_LEVEL: main_level = data[LEVEL_BITS-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned root, b;
			root = 0;
			b = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= root + b) begin
					n -= root + b;
					root = (root >> 1) + b;
				end else
					root >>= 1;
				b >>= 2;
			end
			return root;
		endfunction

		// quadratic fall-off; 0 at or beyond the range
		function longint unsigned attenuate(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
				logic [COORD_W-1:0] lx, logic [COORD_W-1:0] ly, logic [RANGE_BITS-1:0] rng);
			longint a, b;
			longint unsigned dx, dy, d, r, rl;
			rl = rng;
			a = $signed(sx); b = $signed(lx);
			dx = (a >= b) ? a - b : b - a;
			a = $signed(sy); b = $signed(ly);
			dy = (a >= b) ? a - b : b - a;
			if (dx >= rl || dy >= rl)
				return 0;
			if (dx * dx + dy * dy >= rl * rl)
				return 0;
			d = int_sqrt(dx * dx + dy * dy);
			r = ((rl - d) << DEF_RATIO_FRAC_BITS) / rl;
			return (longint'(DEF_FULL_VOLUME) * r * r) >> (2 * DEF_RATIO_FRAC_BITS);
		endfunction

		function void note_command(logic [ACTION_BITS-1:0] act, logic [COORD_W-1:0] sx,
				logic [COORD_W-1:0] sy, logic [COORD_W-1:0] lx, logic [COORD_W-1:0] ly);
			longint unsigned v, s;
			sound_word_t w;
			v = 0; s = 0; w.aud = 0;
			case (act)
				ACT_EXPLOSION: begin
					v = attenuate(sx, sy, lx, ly, expl_range);
					s = v * 2 * master / 128;
				end
				ACT_COLLISION: begin
					v = attenuate(sx, sy, lx, ly, coll_range);
					s = v * master / 128;
				end
				ACT_ENGINE_START: begin
					v = attenuate(sx, sy, lx, ly, eng_range);
					s = v * master / 128;
				end
				ACT_ENGINE_UPD: begin
					v = attenuate(sx, sy, lx, ly, eng_range);
					s = v * master / 512;
				end
				ACT_MAIN_ENGINE: begin
					v = main_level;
					s = v * master / 128;
					w.aud = 1;
				end
				default: ;
			endcase
			if (act <= ACT_ENGINE_UPD && v != 0)
				w.aud = 1;
			if (s > SCALED_MAX)
				s = SCALED_MAX;
			w.vol = v[VOL_BITS-1:0];
			w.scaled = s[SCALED_BITS-1:0];
			pending_words.insert(pending_words.size(), w);
		endfunction

		function void check_word(logic [VOL_BITS-1:0] vol, logic [SCALED_BITS-1:0] scaled,
				logic aud);
			sound_word_t w;
			if (pending_words.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
				return;
			end
			w = pending_words.pop_front();
			if (vol !== w.vol) begin
				$error("volume: expected %0d, got %0d", w.vol, vol);
				errors++;
			end
			if (scaled !== w.scaled) begin
				$error("scaled_volume: expected %0d, got %0d", w.scaled, scaled);
				errors++;
			end
			if (aud !== w.aud) begin
				$error("audible: expected %0d, got %0d", w.aud, aud);
				errors++;
			end
		endfunction
	endclass

	logic                      clk, arst_n, start, busy;
	logic [ACTION_BITS-1:0]    action;
	logic [COORD_W-1:0]        sound_x, sound_y, listener_x, listener_y;
	logic                      cfg_valid, cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [RANGE_BITS-1:0]     cfg_data;
	logic                      done, audible;
	logic [VOL_BITS-1:0]       volume;
	logic [SCALED_BITS-1:0]    scaled_volume;

	attenuation_scoreboard sb = new();

	distance_volume_attenuator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.sound_x(sound_x), .sound_y(sound_y), .listener_x(listener_x),
		.listener_y(listener_y), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .volume(volume),
		.scaled_volume(scaled_volume), .audible(audible)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watch the three channels at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.note_reg_write(cfg_index, cfg_data);
			if (start && !busy)
				sb.note_command(action, sound_x, sound_y, listener_x, listener_y);
			if (done)
				sb.check_word(volume, scaled_volume, audible);
		end
	end

	// one command word; start is left high for a following word
	task automatic send_cmd(logic [ACTION_BITS-1:0] a, logic [COORD_W-1:0] sx,
			logic [COORD_W-1:0] sy, logic [COORD_W-1:0] lx, logic [COORD_W-1:0] ly);
		start <= 1'b1;
		action <= a;
		sound_x <= sx; sound_y <= sy; listener_x <= lx; listener_y <= ly;
		@(posedge clk iff !busy);
	endtask

	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// one register word; valid is left high for a following word
	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [RANGE_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk iff cfg_ready);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending_words.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	function automatic logic [RANGE_BITS-1:0] range_of(logic [ACTION_BITS-1:0] a);
		case (a)
			ACT_EXPLOSION: return sb.expl_range;
			ACT_COLLISION: return sb.coll_range;
			default:       return sb.eng_range;
		endcase
	endfunction

	// coordinate from a plain integer, two's complement at the port width
	function automatic logic [COORD_W-1:0] crd(int v);
		return COORD_W'(v);
	endfunction

	// mostly sources within hearing distance, some anywhere, some bad kinds
	task automatic send_random();
		logic [ACTION_BITS-1:0] a;
		logic [COORD_W-1:0]     lx, ly, sx, sy;
		int                     rng, pick;
		pick = $urandom_range(0, 99);
		a = (pick < 90) ? ACTION_BITS'($urandom_range(ACT_EXPLOSION, ACT_MAIN_ENGINE))
			: ACTION_BITS'($urandom_range(0, 7));
		lx = COORD_W'($urandom); ly = COORD_W'($urandom);
		sx = COORD_W'($urandom); sy = COORD_W'($urandom);
		rng = int'(range_of(a));
		if (pick < 75) begin
			if ($urandom_range(0, 3) == 0 && rng > 64)
				rng = 64;
			sx = COORD_W'(int'(lx) + (int'($urandom_range(0, 2 * rng)) - rng));
			sy = COORD_W'(int'(ly) + (int'($urandom_range(0, 2 * rng)) - rng));
		end
		send_cmd(a, sx, sy, lx, ly);
	endtask

	localparam logic [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};

	int idle_pct[PHASES] = '{0, 49, 0, 14, 49};
	logic [RANGE_BITS-1:0] cfg_set[PHASES][5] = '{
		'{19'd64, 19'd4096, 19'd2048, 19'd2048, 19'd64},
		'{19'd128, 19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 19'd128},
		'{19'd0, 19'd1, 19'd1, 19'd1, 19'd0},
		'{19'd255, 19'd0, 19'd100, 19'd5000, 19'd255},
		'{19'd100, 19'd300, 19'd20000, 19'd0, 19'd1}
	};

	initial begin
		arst_n = 0; start = 0; cfg_valid = 0; cfg_index = REG_MASTER; cfg_data = 0;
		action = ACT_EXPLOSION;
		sound_x = 0; sound_y = 0; listener_x = 0; listener_y = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at reset settings
		send_cmd(ACT_MAIN_ENGINE, CMIN, CMAX, crd(0), crd(0));
		send_cmd(ACT_EXPLOSION, crd(0), crd(0), crd(0), crd(0));
		send_cmd(ACT_COLLISION, crd(5), crd(-7), crd(5), crd(-7));
		send_cmd(ACT_ENGINE_START, crd(10), crd(10), crd(10), crd(10));
		send_cmd(ACT_ENGINE_UPD, crd(0), crd(0), crd(0), crd(0));
		send_cmd(ACT_EXPLOSION, crd(4096), crd(0), crd(0), crd(0));
		send_cmd(ACT_EXPLOSION, crd(0), crd(4095), crd(0), crd(0));
		send_cmd(ACT_COLLISION, crd(-2047), crd(0), crd(0), crd(0));
		send_cmd(ACT_COLLISION, crd(1200), crd(1600), crd(0), crd(0));
		send_cmd(ACT_ENGINE_START, crd(1229), crd(1639), crd(0), crd(0));
		send_cmd(ACT_ENGINE_UPD, crd(300), crd(-400), crd(0), crd(0));
		send_cmd(ACT_EXPLOSION, crd(2000), crd(2000), crd(0), crd(0));
		send_cmd(ACT_EXPLOSION, CMAX, CMAX, CMIN, CMIN);
		send_cmd(ACT_COLLISION, CMIN, crd(0), CMAX, crd(0));
		send_cmd(3'd5, crd(0), crd(0), crd(0), crd(0));
		send_cmd(3'd6, crd(1), crd(1), crd(1), crd(1));
		send_cmd(3'd7, CMAX, CMIN, CMAX, CMIN);
		send_cmd(ACT_EXPLOSION, crd(0), crd(0), crd(100), crd(100));

		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_reg(REG_MASTER, cfg_set[p][0]);
			write_reg(REG_EXPL_RANGE, cfg_set[p][1]);
			write_reg(REG_COLL_RANGE, cfg_set[p][2]);
			write_reg(REG_ENG_RANGE, cfg_set[p][3]);
			write_reg(REG_MAIN_LEVEL, cfg_set[p][4]);
			cfg_valid <= 1'b0;
			for (int i = 0; i < RAND_PER; i++) begin
				if ($urandom_range(0, 99) < idle_pct[p])
					idle_cycles($urandom_range(1, 4));
				send_random();
			end
		end

		drain();
		if (sb.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// overall time limit
	initial begin
		#2000000;
		$display("tb_top: FAIL");
		$finish;
	end
endmodule
